// ===== hdl/c8alu_pkg.sv =====
// Shared operation codes, status bit positions and register-file type for the 8-bit ALU.
package c8alu_pkg;

    localparam int OP_W   = 5;
    localparam int DATA_W = 8;

    localparam logic [OP_W-1:0] OP_ORA = 5'd0;
    localparam logic [OP_W-1:0] OP_AND = 5'd1;
    localparam logic [OP_W-1:0] OP_EOR = 5'd2;
    localparam logic [OP_W-1:0] OP_ADC = 5'd3;
    localparam logic [OP_W-1:0] OP_SBC = 5'd4;
    localparam logic [OP_W-1:0] OP_CMP = 5'd5;
    localparam logic [OP_W-1:0] OP_CPX = 5'd6;
    localparam logic [OP_W-1:0] OP_CPY = 5'd7;
    localparam logic [OP_W-1:0] OP_BIT = 5'd8;
    localparam logic [OP_W-1:0] OP_LDA = 5'd9;
    localparam logic [OP_W-1:0] OP_LDX = 5'd10;
    localparam logic [OP_W-1:0] OP_LDY = 5'd11;
    localparam logic [OP_W-1:0] OP_STA = 5'd12;
    localparam logic [OP_W-1:0] OP_STX = 5'd13;
    localparam logic [OP_W-1:0] OP_STY = 5'd14;
    localparam logic [OP_W-1:0] OP_INC = 5'd15;
    localparam logic [OP_W-1:0] OP_DEC = 5'd16;
    localparam logic [OP_W-1:0] OP_ASL = 5'd17;
    localparam logic [OP_W-1:0] OP_LSR = 5'd18;
    localparam logic [OP_W-1:0] OP_ROL = 5'd19;
    localparam logic [OP_W-1:0] OP_ROR = 5'd20;
    localparam logic [OP_W-1:0] OP_PHP = 5'd21;
    localparam logic [OP_W-1:0] OP_PLP = 5'd22;
    localparam logic [OP_W-1:0] OP_PLA = 5'd23;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_B = 4;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [DATA_W-1:0] PUSH_MASK = 8'h30;
    localparam logic [DATA_W-1:0] PULL_MASK = 8'hEF;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] p;
    } t_regs;

endpackage

// ===== hdl/c8alu_exec.sv =====
// Combinational execute step: one operation on A, X, Y and status with one data byte.
module c8alu_exec (
    input  logic [c8alu_pkg::OP_W-1:0]   i_op,
    input  logic [c8alu_pkg::DATA_W-1:0] i_operand,
    input  c8alu_pkg::t_regs             i_regs,
    output c8alu_pkg::t_regs             o_regs,
    output logic [c8alu_pkg::DATA_W-1:0] o_result
);
    import c8alu_pkg::*;

    logic [DATA_W-1:0] addend;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] cmp_reg;
    logic [DATA_W:0]   diff;
    logic              cin;

    // Replace Z and N in a status byte from a value.
    function automatic logic [DATA_W-1:0] set_zn(input logic [DATA_W-1:0] p,
                                                 input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] q;
        q         = p;
        q[FLAG_Z] = (v == '0);
        q[FLAG_N] = v[DATA_W-1];
        return q;
    endfunction

    assign cin     = i_regs.p[FLAG_C];
    // SBC runs through the adder as A + ~M + C
    assign addend  = (i_op == OP_SBC) ? ~i_operand : i_operand;
    assign sum     = {1'b0, i_regs.a} + {1'b0, addend} + {{DATA_W{1'b0}}, cin};
    assign cmp_reg = (i_op == OP_CPX) ? i_regs.x :
                     (i_op == OP_CPY) ? i_regs.y : i_regs.a;
    assign diff    = {1'b0, cmp_reg} - {1'b0, i_operand};

    always_comb begin
        o_regs   = i_regs;
        o_result = '0;
        unique case (i_op)
            OP_ORA, OP_AND, OP_EOR: begin
                if (i_op == OP_ORA) begin
                    o_result = i_regs.a | i_operand;
                end else if (i_op == OP_AND) begin
                    o_result = i_regs.a & i_operand;
                end else begin
                    o_result = i_regs.a ^ i_operand;
                end
                o_regs.a = o_result;
                o_regs.p = set_zn(i_regs.p, o_result);
            end
            OP_ADC, OP_SBC: begin
                o_result         = sum[DATA_W-1:0];
                o_regs.a         = o_result;
                o_regs.p         = set_zn(i_regs.p, o_result);
                o_regs.p[FLAG_C] = sum[DATA_W];
                o_regs.p[FLAG_V] = ~(i_regs.a[DATA_W-1] ^ addend[DATA_W-1])
                                   & (i_regs.a[DATA_W-1] ^ o_result[DATA_W-1]);
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                o_result         = diff[DATA_W-1:0];
                o_regs.p         = set_zn(i_regs.p, o_result);
                // no borrow means reg >= M
                o_regs.p[FLAG_C] = ~diff[DATA_W];
            end
            OP_BIT: begin
                o_result         = i_regs.a & i_operand;
                o_regs.p[FLAG_Z] = (o_result == '0);
                o_regs.p[FLAG_V] = i_operand[FLAG_V];
                o_regs.p[FLAG_N] = i_operand[FLAG_N];
            end
            OP_LDA, OP_PLA: begin
                o_result = i_operand;
                o_regs.a = i_operand;
                o_regs.p = set_zn(i_regs.p, i_operand);
            end
            OP_LDX: begin
                o_result = i_operand;
                o_regs.x = i_operand;
                o_regs.p = set_zn(i_regs.p, i_operand);
            end
            OP_LDY: begin
                o_result = i_operand;
                o_regs.y = i_operand;
                o_regs.p = set_zn(i_regs.p, i_operand);
            end
            OP_STA: o_result = i_regs.a;
            OP_STX: o_result = i_regs.x;
            OP_STY: o_result = i_regs.y;
            OP_INC, OP_DEC: begin
                if (i_op == OP_INC) begin
                    o_result = i_operand + {{(DATA_W-1){1'b0}}, 1'b1};
                end else begin
                    o_result = i_operand - {{(DATA_W-1){1'b0}}, 1'b1};
                end
                o_regs.p = set_zn(i_regs.p, o_result);
            end
            OP_ASL, OP_ROL: begin
                o_result         = {i_operand[DATA_W-2:0], (i_op == OP_ROL) & cin};
                o_regs.p         = set_zn(i_regs.p, o_result);
                o_regs.p[FLAG_C] = i_operand[DATA_W-1];
            end
            OP_LSR, OP_ROR: begin
                o_result         = {(i_op == OP_ROR) & cin, i_operand[DATA_W-1:1]};
                o_regs.p         = set_zn(i_regs.p, o_result);
                o_regs.p[FLAG_C] = i_operand[0];
            end
            OP_PHP: o_result = i_regs.p | PUSH_MASK;
            OP_PLP: begin
                o_regs.p = i_operand & PULL_MASK;
                o_result = i_operand & PULL_MASK;
            end
            default: o_result = '0;
        endcase
    end

endmodule

// ===== hdl/cpu8_alu_register_flags.sv =====
// Top level: input register, execute step with architectural registers, result register.
// One operation retires per clock when the result side keeps taking transfers: an accepted
// item is held in the input register, executes against A, X, Y and status as it moves to
// the result register, and is then offered on o_valid. Each operation's register
// update is committed when its result enters the result register, so the next item always
// sees the state left by the previous one. A stalled output holds its result, and the input
// register keeps taking one more item behind it.
module cpu8_alu_register_flags (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [c8alu_pkg::OP_W-1:0]    i_op,
    input  logic [c8alu_pkg::DATA_W-1:0]  i_operand,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [c8alu_pkg::DATA_W-1:0]  o_result,
    output logic [c8alu_pkg::DATA_W-1:0]  o_flags
);
    import c8alu_pkg::*;

    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [DATA_W-1:0] r_in_operand;
    t_regs             r_regs;
    t_regs             n_regs;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_result;
    logic [DATA_W-1:0] n_result;
    logic [DATA_W-1:0] r_flags;
    logic              advance;

    c8alu_exec u_exec (
        .i_op      (r_in_op),
        .i_operand (r_in_operand),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_result  (n_result)
    );

    // advance the held item when the result register is free or being drained
    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;
    assign o_valid = r_out_valid;
    assign o_result = r_result;
    assign o_flags  = r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op      <= i_op;
            r_in_operand <= i_operand;
        end
        if (advance) begin
            r_result <= n_result;
            r_flags  <= n_regs.p;
        end
    end

    a_store_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_op == OP_STA || r_in_op == OP_STX || r_in_op == OP_STY)
        |=> r_regs == $past(r_regs))
        else $error("store changed register state");

    a_plp_clears_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_op == OP_PLP |=> !r_regs.p[FLAG_B] && r_result == r_regs.p)
        else $error("PLP status mismatch");

    a_php_sets_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_op == OP_PHP |=> r_result[5] && r_result[FLAG_B])
        else $error("PHP push byte missing bits");

    a_lda_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_op == OP_LDA || r_in_op == OP_PLA)
        |=> r_regs.a == $past(r_in_operand) && r_result == r_regs.a)
        else $error("load did not reach A");

    a_flags_track_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) |-> r_flags == r_regs.p)
        else $error("flags output differs from status");

endmodule
